// ----- src/bphd_pkg.sv -----
// shared types and constants for the button press / hold debouncer
// no dependencies
`default_nettype none

package bphd_pkg;

   localparam int FAST_WIDTH = 8;
   localparam int SLOW_WIDTH = 16;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [FAST_WIDTH-1:0] PRESS_THRESHOLD_RESET = 8'd200;
   localparam logic [SLOW_WIDTH-1:0] HOLD_THRESHOLD_RESET = 16'd122;

   // register indexes on the csr port
   localparam logic CSR_PRESS_THRESHOLD = 1'b0;
   localparam logic CSR_HOLD_THRESHOLD = 1'b1;

   typedef struct packed {
      logic                  button_level;
      logic [FAST_WIDTH-1:0] fast_time;
      logic [SLOW_WIDTH-1:0] slow_time;
   } req_type;

   typedef struct packed {
      logic press_event;
      logic hold_event;
   } rsp_type;

   typedef struct packed {
      logic [FAST_WIDTH-1:0] press_threshold;
      logic [SLOW_WIDTH-1:0] hold_threshold;
   } thresh_type;

endpackage

`default_nettype wire

// ----- src/button_press_hold_debouncer.sv -----
// top level of the button press / hold debouncer: poll register, result register, csrs
// depends on bphd_pkg and bphd_core
`default_nettype none

// Polls the active-low button with snapshots of a fast 8-bit and a slow 16-bit
// free-running timer and returns exactly one result beat per poll beat, carrying
// press_event (a latched short press, reported on release) and hold_event (fires
// once when the slow-timer span since the press exceeds hold_threshold, cancelling
// the short press). Each poll passes through an input register and then a result
// register, from which its result is presented; a new poll can be accepted every
// cycle while the result channel does not stall; throughput is one poll per clock
// under that condition, set by the combinational decision logic between the two
// registers. Threshold registers are written through the csr port (always ready)
// and must be written only while no poll is in flight.
module button_press_hold_debouncer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // poll channel
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire bphd_pkg::req_type                   req_data,
   // result channel
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      bphd_pkg::rsp_type                   rsp_data,
   // configuration write channel
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic                                csr_index,
   input  wire logic [bphd_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   logic                 in_valid_ff, in_valid_in;
   bphd_pkg::req_type    in_data_ff;
   logic                 out_valid_ff, out_valid_in;
   bphd_pkg::rsp_type    out_data_ff;
   bphd_pkg::rsp_type    core_result;
   bphd_pkg::thresh_type thresh_ff;
   logic                 advance;
   logic                 req_take;

   // the result register frees up when empty or when its beat is taken
   assign advance   = ~out_valid_ff | ~rsp_stall;
   // the poll register takes a beat when empty or when it moves on
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance && in_valid_ff) begin
         out_data_ff <= core_result;
      end
   end

   // state flags step once per poll, as it moves into the result register
   bphd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance & in_valid_ff),
      .item    (in_data_ff),
      .thresh  (thresh_ff),
      .result  (core_result)
   );

   // threshold registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.press_threshold <= bphd_pkg::PRESS_THRESHOLD_RESET;
         thresh_ff.hold_threshold  <= bphd_pkg::HOLD_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bphd_pkg::CSR_PRESS_THRESHOLD: begin
               thresh_ff.press_threshold <= csr_wdata[bphd_pkg::FAST_WIDTH-1:0];
            end
            bphd_pkg::CSR_HOLD_THRESHOLD: begin
               thresh_ff.hold_threshold <= csr_wdata[bphd_pkg::SLOW_WIDTH-1:0];
            end
            default: begin
               thresh_ff <= thresh_ff;
            end
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ----- src/bphd_core.sv -----
// debounce decision logic and button state flags
// depends on bphd_pkg
`default_nettype none

module bphd_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  wire bphd_pkg::req_type    item,
   input  wire bphd_pkg::thresh_type thresh,
   output bphd_pkg::rsp_type         result
);

   logic                                down_seen_ff, down_seen_in;
   logic                                press_latched_ff, press_latched_in;
   logic                                press_detected_ff, press_detected_in;
   logic                                hold_fired_ff, hold_fired_in;
   logic [bphd_pkg::FAST_WIDTH-1:0]     fast_start_ff, fast_start_in;
   logic [bphd_pkg::SLOW_WIDTH-1:0]     slow_start_ff, slow_start_in;
   logic [bphd_pkg::FAST_WIDTH-1:0]     fast_diff;
   logic [bphd_pkg::SLOW_WIDTH-1:0]     slow_diff;
   logic                                pressed;

   // differences wrap at the timer widths
   assign fast_diff = item.fast_time - fast_start_ff;
   assign slow_diff = item.slow_time - slow_start_ff;
   assign pressed   = ~item.button_level;

   always_comb begin
      down_seen_in      = down_seen_ff;
      press_latched_in  = press_latched_ff;
      press_detected_in = press_detected_ff;
      hold_fired_in     = hold_fired_ff;
      fast_start_in     = fast_start_ff;
      slow_start_in     = slow_start_ff;
      result            = '0;
      if (pressed) begin
         if (!down_seen_ff) begin
            // first down poll: record start points and clear the flags, no event
            fast_start_in     = item.fast_time;
            slow_start_in     = item.slow_time;
            down_seen_in      = 1'b1;
            press_latched_in  = 1'b0;
            press_detected_in = 1'b0;
            hold_fired_in     = 1'b0;
         end else if (!press_detected_ff && (fast_diff > thresh.press_threshold)) begin
            press_latched_in  = 1'b1;
            press_detected_in = 1'b1;
         end else if (!hold_fired_ff && (slow_diff > thresh.hold_threshold)) begin
            result.hold_event = 1'b1;
            hold_fired_in     = 1'b1;
            press_latched_in  = 1'b0;
         end
      end else if (down_seen_ff) begin
         if (press_latched_ff) begin
            result.press_event = 1'b1;
            press_latched_in   = 1'b0;
         end
         // slow start point is kept on release
         fast_start_in = item.fast_time;
         down_seen_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_seen_ff      <= 1'b0;
         press_latched_ff  <= 1'b0;
         press_detected_ff <= 1'b0;
         hold_fired_ff     <= 1'b0;
         fast_start_ff     <= '0;
         slow_start_ff     <= '0;
      end else if (step_en) begin
         down_seen_ff      <= down_seen_in;
         press_latched_ff  <= press_latched_in;
         press_detected_ff <= press_detected_in;
         hold_fired_ff     <= hold_fired_in;
         fast_start_ff     <= fast_start_in;
         slow_start_ff     <= slow_start_in;
      end
   end

endmodule

`default_nettype wire
